/* sv/sfr_pkg.sv */
// Shared types and constants for the substring find-and-replace block.
// Used by sfr_cfg, sfr_cell and substring_find_and_replace; no dependencies.
package sfr_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 5;
	localparam int CNT_W  = 16;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// register indexes (byte address / 8)
	localparam logic [2:0] REG_PAT_LO  = 3'd0;
	localparam logic [2:0] REG_PAT_HI  = 3'd1;
	localparam logic [2:0] REG_PAT_LEN = 3'd2;
	localparam logic [2:0] REG_REP_LO  = 3'd3;
	localparam logic [2:0] REG_REP_HI  = 3'd4;
	localparam logic [2:0] REG_REP_LEN = 3'd5;

	typedef struct packed {
		logic [DATA_W-1:0] pat_lo;
		logic [DATA_W-1:0] pat_hi;
		logic [DATA_W-1:0] rep_lo;
		logic [DATA_W-1:0] rep_hi;
		logic [LEN_W-1:0]  plen;     // clamped to 1..MAX_PATTERN
		logic [LEN_W-1:0]  rlen;     // clamped to 0..MAX_REPLACEMENT
		logic              plen_wr;  // pattern length written this cycle
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_REPL,
		ST_FLUSH
	} st_t;

	function automatic logic [BYTE_W-1:0] pick_byte(
		input logic [DATA_W-1:0]  lo,
		input logic [DATA_W-1:0]  hi,
		input logic [LEN_W-2:0]   idx
	);
		logic [DATA_W-1:0] w;
		w = idx[LEN_W-2] ? hi : lo;
		return w[idx[2:0]*BYTE_W +: BYTE_W];
	endfunction

endpackage

/* sv/substring_find_and_replace.sv */
// Top level of the streaming find-and-replace block: control sequencer, window
// cell chain and output register. Depends on sfr_pkg, sfr_cfg, sfr_cell.
//
//  port group | dir | carries
//  -----------+-----+---------------------------------------------------------
//  s_*        | in  | text bytes; tdata = text_byte, tlast = text_last
//  m_*        | out | rewritten bytes; tdata/tuser/tlast as listed at the ports
//  p*         | in  | APB register access, 64-bit data, register i at 8*i
//
// Each text byte is accepted, then compared, then hands over the results it causes,
// at most 16 results with the default parameters.
// Reset clears control state; the window cells hold no reset value.
// A stalled output holds the sequencer; no new byte is taken until the
// previous one has handed over all its results.
module substring_find_and_replace #(
	parameter int MAX_PATTERN     = 16,
	parameter int MAX_REPLACEMENT = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfr_pkg::ADDR_W-1:0]  paddr,
	input  logic [sfr_pkg::DATA_W-1:0]  pwdata,
	output logic [sfr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] text_byte
	input  logic                        s_tlast,   // text_last
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [31:0]                 m_tdata,   // [7:0] out_byte, [8] text_done,
	                                               // [24:9] replace_count, rest zero
	output logic                        m_tuser,   // byte_valid
	output logic                        m_tlast    // run_last
);
	import sfr_pkg::*;

	localparam int FW = $clog2(MAX_PATTERN + 1);

	cfg_t cfg;

	st_t               state_q, state_d;
	logic [FW-1:0]     fill_q, fill_d, wr_pos;
	logic              last_q;
	logic [CNT_W-1:0]  count_q, count_d, count_inc;
	logic [LEN_W-2:0]  rep_idx_q, rep_idx_d;

	logic              accept, slot_free, emit, shift, full, hit;
	logic [BYTE_W-1:0] e_byte;
	logic              e_bv, e_last, e_done;
	logic [CNT_W-1:0]  e_count;

	logic              ovalid_q;
	logic [BYTE_W-1:0] obyte_q;
	logic              obv_q, olast_q, odone_q;
	logic [CNT_W-1:0]  ocount_q;

	logic [BYTE_W-1:0] cell_q [MAX_PATTERN];
	logic              chain  [MAX_PATTERN+1];

	sfr_cfg #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign slot_free = ~ovalid_q | m_tready;
	// a stale fill at or beyond the pattern length restarts the window
	assign wr_pos    = (LEN_W'(fill_q) >= cfg.plen) ? '0 : fill_q;
	assign full      = (LEN_W'(fill_q) == cfg.plen);
	assign count_inc = (count_q == '1) ? count_q : count_q + CNT_W'(1);

	assign chain[MAX_PATTERN] = 1'b1;
	assign hit                = chain[0];

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [BYTE_W-1:0] nbr;
		if (i == MAX_PATTERN - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_q[i+1];
		end
		sfr_cell u_cell (
			.clk       (clk),
			.load      (accept && (wr_pos == FW'(i))),
			.shift     (shift),
			.din       (s_tdata),
			.nbr       (nbr),
			.pat       (pick_byte(cfg.pat_lo, cfg.pat_hi, (LEN_W-1)'(i))),
			.active    (LEN_W'(i) < cfg.plen),
			.match_in  (chain[i+1]),
			.match_out (chain[i]),
			.q         (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			last_q    <= 1'b0;
			count_q   <= '0;
			rep_idx_q <= '0;
		end else begin
			state_q   <= state_d;
			fill_q    <= cfg.plen_wr ? '0 : fill_d;
			count_q   <= count_d;
			rep_idx_q <= rep_idx_d;
			if (accept)
				last_q <= s_tlast;
		end
	end

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		count_d   = count_q;
		rep_idx_d = rep_idx_q;
		emit      = 1'b0;
		shift     = 1'b0;
		e_byte    = cell_q[0];
		e_bv      = 1'b1;
		e_last    = 1'b0;
		e_done    = 1'b0;
		e_count   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					fill_d  = wr_pos + FW'(1);
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (slot_free) begin
					if (full && hit) begin
						fill_d  = '0;
						count_d = count_inc;
						if (cfg.rlen != '0) begin
							rep_idx_d = '0;
							state_d   = ST_REPL;
						end else begin
							state_d = ST_IDLE;
							if (last_q) begin
								// match deleted at end of text: count-only result
								emit    = 1'b1;
								e_byte  = '0;
								e_bv    = 1'b0;
								e_last  = 1'b1;
								e_done  = 1'b1;
								e_count = count_inc;
								count_d = '0;
							end
						end
					end else if (full) begin
						emit   = 1'b1;
						shift  = 1'b1;
						fill_d = fill_q - FW'(1);
						if (!last_q) begin
							e_last  = 1'b1;
							state_d = ST_IDLE;
						end else if (fill_q == FW'(1)) begin
							e_last  = 1'b1;
							e_done  = 1'b1;
							e_count = count_q;
							count_d = '0;
							state_d = ST_IDLE;
						end else begin
							state_d = ST_FLUSH;
						end
					end else begin
						state_d = last_q ? ST_FLUSH : ST_IDLE;
					end
				end
			end
			ST_REPL: begin
				if (slot_free) begin
					emit   = 1'b1;
					e_byte = pick_byte(cfg.rep_lo, cfg.rep_hi, rep_idx_q);
					if ((LEN_W'(rep_idx_q) + LEN_W'(1)) == cfg.rlen) begin
						e_last  = 1'b1;
						state_d = ST_IDLE;
						if (last_q) begin
							e_done  = 1'b1;
							e_count = count_q;
							count_d = '0;
						end
					end else begin
						rep_idx_d = rep_idx_q + (LEN_W-1)'(1);
					end
				end
			end
			ST_FLUSH: begin
				if (slot_free) begin
					emit   = 1'b1;
					shift  = 1'b1;
					fill_d = fill_q - FW'(1);
					if (fill_q == FW'(1)) begin
						e_last  = 1'b1;
						e_done  = 1'b1;
						e_count = count_q;
						count_d = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (emit)
			ovalid_q <= 1'b1;
		else if (m_tready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			obyte_q  <= e_byte;
			obv_q    <= e_bv;
			olast_q  <= e_last;
			odone_q  <= e_done;
			ocount_q <= e_count;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {7'd0, ocount_q, odone_q, obyte_q};
	assign m_tuser  = obv_q;
	assign m_tlast  = olast_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_PATTERN))
		else $error("window fill beyond cell count");
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EVAL)
		else $error("accepted item not evaluated");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[8] |-> m_tlast)
		else $error("text end not on last result of item");
	a_count_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[8])
		else $error("count-only result without text end");
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[8] |-> m_tdata[24:9] == '0)
		else $error("count shown before text end");
`endif

endmodule

/* sv/sfr_cfg.sv */
// APB register file for the find-and-replace block: pattern, replacement, lengths.
// Depends on sfr_pkg.
module sfr_cfg #(
	parameter int MAX_PATTERN     = 16,
	parameter int MAX_REPLACEMENT = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sfr_pkg::ADDR_W-1:0]   paddr,
	input  logic [sfr_pkg::DATA_W-1:0]   pwdata,
	output logic [sfr_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output sfr_pkg::cfg_t                cfg
);
	import sfr_pkg::*;

	logic [DATA_W-1:0] pat_lo_q, pat_hi_q, rep_lo_q, rep_hi_q;
	logic [LEN_W-1:0]  plen_q, rlen_q;
	logic              wr_en;
	logic [2:0]        idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			rep_lo_q <= '0;
			rep_hi_q <= '0;
			plen_q   <= LEN_W'(1);
			rlen_q   <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_PAT_LO:  pat_lo_q <= pwdata;
				REG_PAT_HI:  pat_hi_q <= pwdata;
				REG_PAT_LEN: plen_q   <= pwdata[LEN_W-1:0];
				REG_REP_LO:  rep_lo_q <= pwdata;
				REG_REP_HI:  rep_hi_q <= pwdata;
				REG_REP_LEN: rlen_q   <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PAT_LO:  prdata = pat_lo_q;
			REG_PAT_HI:  prdata = pat_hi_q;
			REG_PAT_LEN: prdata = DATA_W'(plen_q);
			REG_REP_LO:  prdata = rep_lo_q;
			REG_REP_HI:  prdata = rep_hi_q;
			REG_REP_LEN: prdata = DATA_W'(rlen_q);
			default:     prdata = '0;
		endcase
	end

	always_comb begin
		cfg.pat_lo  = pat_lo_q;
		cfg.pat_hi  = pat_hi_q;
		cfg.rep_lo  = rep_lo_q;
		cfg.rep_hi  = rep_hi_q;
		if (plen_q == '0)
			cfg.plen = LEN_W'(1);
		else if (plen_q > LEN_W'(MAX_PATTERN))
			cfg.plen = LEN_W'(MAX_PATTERN);
		else
			cfg.plen = plen_q;
		cfg.rlen    = (rlen_q > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : rlen_q;
		cfg.plen_wr = wr_en & (idx == REG_PAT_LEN);
	end

endmodule

/* sv/sfr_cell.sv */
// One window cell: holds a text byte, shifts towards cell 0, compares with its
// pattern byte and extends the match chain. Depends on sfr_pkg.
module sfr_cell (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        shift,
	input  logic [sfr_pkg::BYTE_W-1:0]  din,
	input  logic [sfr_pkg::BYTE_W-1:0]  nbr,
	input  logic [sfr_pkg::BYTE_W-1:0]  pat,
	input  logic                        active,
	input  logic                        match_in,
	output logic                        match_out,
	output logic [sfr_pkg::BYTE_W-1:0]  q
);
	import sfr_pkg::*;

	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (load)
			byte_q <= din;
		else if (shift)
			byte_q <= nbr;
	end

	assign q         = byte_q;
	assign match_out = match_in & (~active | (byte_q == pat));

endmodule
